FILE: hw/rtl/ice_pkg.sv
// Shared constants, types and a helper function for the internet checksum engine.
`timescale 1ns / 1ps
package ice_pkg;

   localparam int WORD_W     = 32;
   localparam int BCNT_W     = 3;
   localparam int SUM_W      = 16;
   localparam int LEN_W      = 32;
   localparam int MODE_W     = 2;
   localparam int PROTO_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int WIDE_SUM_W = SUM_W + 3;

   localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_IPV4 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_IPV6 = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PSEUDO_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROTOCOL    = 1'b1;

   localparam logic [PROTO_W-1:0] PROTOCOL_RESET = 8'd6;
   localparam logic [BCNT_W-1:0]  FULL_WORD_BYTES = 3'd4;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [LEN_W-1:0] len;
   } ice_total_type;

   typedef struct packed {
      logic [MODE_W-1:0]  pseudo_mode;
      logic [PROTO_W-1:0] protocol_number;
   } ice_cfg_type;

   // Fold a multi-operand sum down to 16 bits with end-around carry.
   function automatic logic [SUM_W-1:0] oc_fold(input logic [WIDE_SUM_W-1:0] t);
      logic [SUM_W:0] f1;
      f1 = {1'b0, t[SUM_W-1:0]} + (SUM_W+1)'(t[WIDE_SUM_W-1:SUM_W]);
      oc_fold = f1[SUM_W-1:0] + SUM_W'(f1[SUM_W]);
   endfunction

endpackage

FILE: hw/rtl/ice_req_if.sv
// Input channel carrying packet words into the checksum engine.
`timescale 1ns / 1ps
interface ice_req_if;
   logic                          valid;
   logic                          ready;
   logic [ice_pkg::WORD_W-1:0]    data_word;
   logic [ice_pkg::BCNT_W-1:0]    byte_count;
   logic                          is_address;
   logic                          last;

   modport source (output valid, data_word, byte_count, is_address, last, input ready);
   modport sink   (input valid, data_word, byte_count, is_address, last, output ready);
endinterface

FILE: hw/rtl/ice_rsp_if.sv
// Result channel carrying the checksum and segment length out of the engine.
`timescale 1ns / 1ps
interface ice_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ice_pkg::SUM_W-1:0]     checksum;
   logic [ice_pkg::LEN_W-1:0]     segment_length;

   modport source (output valid, checksum, segment_length, input ready);
   modport sink   (input valid, checksum, segment_length, output ready);
endinterface

FILE: hw/rtl/ice_accum.sv
// Input register and per-packet accumulator for the ones'-complement sum and byte count.
`timescale 1ns / 1ps
module ice_accum (
   input  logic                  clock,
   input  logic                  reset,
   ice_req_if.sink               req_chan,
   output logic                  total_valid,
   input  logic                  total_ready,
   output ice_pkg::ice_total_type total
);
   import ice_pkg::*;

   logic              in_valid_ff;
   logic [WORD_W-1:0] word_ff;
   logic [BCNT_W-1:0] bcnt_ff;
   logic              addr_ff;
   logic              last_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [LEN_W-1:0]  count_ff, count_in;

   logic              a_fire;
   logic              accept;
   logic [BCNT_W-1:0] bcnt_clamp;
   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] masked;
   logic [SUM_W-1:0]  sum_acc;
   logic [LEN_W-1:0]  count_acc;

   // A last beat waits for the finalize stage; other beats always retire.
   assign a_fire         = in_valid_ff && (!last_ff || total_ready);
   assign req_chan.ready = !in_valid_ff || a_fire;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (accept) begin
         word_ff <= req_chan.data_word;
         bcnt_ff <= req_chan.byte_count;
         addr_ff <= req_chan.is_address;
         last_ff <= req_chan.last;
      end
   end

   always_comb begin
      bcnt_clamp = (bcnt_ff > FULL_WORD_BYTES) ? FULL_WORD_BYTES : bcnt_ff;
      case (bcnt_clamp)
         3'd1:    mask = 32'hff00_0000;
         3'd2:    mask = 32'hffff_0000;
         3'd3:    mask = 32'hffff_ff00;
         3'd4:    mask = 32'hffff_ffff;
         default: mask = 32'h0000_0000;
      endcase
      masked    = word_ff & mask;
      sum_acc   = oc_fold(WIDE_SUM_W'(sum_ff) + WIDE_SUM_W'(masked[WORD_W-1:SUM_W])
                          + WIDE_SUM_W'(masked[SUM_W-1:0]));
      count_acc = addr_ff ? count_ff : count_ff + LEN_W'(bcnt_clamp);
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (a_fire) begin
         // drop the state at the end of a packet
         sum_in   = last_ff ? '0 : sum_acc;
         count_in = last_ff ? '0 : count_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   assign total_valid = in_valid_ff && last_ff;
   assign total.sum   = sum_acc;
   assign total.len   = count_acc;

endmodule

FILE: hw/rtl/ice_final.sv
// Pseudo-header addition, complement and result register of the checksum engine.
`timescale 1ns / 1ps
module ice_final (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   total_valid,
   output logic                   total_ready,
   input  ice_pkg::ice_total_type total,
   input  ice_pkg::ice_cfg_type   cfg,
   ice_rsp_if.source              rsp_chan
);
   import ice_pkg::*;

   logic                tot_valid_ff;
   ice_total_type       tot_ff;
   logic                rsp_valid_ff;
   logic [SUM_W-1:0]    checksum_ff;
   logic [LEN_W-1:0]    length_ff;

   logic                c_load;
   logic                b_fire;
   logic [WIDE_SUM_W-1:0] wide_sum;
   logic [SUM_W-1:0]    final_sum;

   assign c_load      = !rsp_valid_ff || rsp_chan.ready;
   assign b_fire      = tot_valid_ff && c_load;
   assign total_ready = !tot_valid_ff || b_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_valid_ff <= 1'b0;
      end else if (total_ready) begin
         tot_valid_ff <= total_valid;
      end
      if (total_valid && total_ready) begin
         tot_ff <= total;
      end
   end

   always_comb begin
      wide_sum = WIDE_SUM_W'(tot_ff.sum);
      case (cfg.pseudo_mode)
         MODE_IPV4: begin
            wide_sum = WIDE_SUM_W'(tot_ff.sum) + WIDE_SUM_W'(tot_ff.len[SUM_W-1:0])
                       + WIDE_SUM_W'(cfg.protocol_number);
         end
         MODE_IPV6: begin
            wide_sum = WIDE_SUM_W'(tot_ff.sum) + WIDE_SUM_W'(tot_ff.len[SUM_W-1:0])
                       + WIDE_SUM_W'(tot_ff.len[LEN_W-1:SUM_W])
                       + WIDE_SUM_W'(cfg.protocol_number);
         end
         default: begin
            wide_sum = WIDE_SUM_W'(tot_ff.sum);
         end
      endcase
      final_sum = oc_fold(wide_sum);
   end

   // hold the result until the receiver takes the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_load) begin
         rsp_valid_ff <= tot_valid_ff;
      end
      if (b_fire) begin
         checksum_ff <= ~final_sum;
         length_ff   <= tot_ff.len;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.checksum       = checksum_ff;
   assign rsp_chan.segment_length = length_ff;

endmodule

FILE: hw/rtl/internet_checksum_engine.sv
// Top level of the internet checksum engine: configuration registers and stage wiring.
//
// Usage: stream a packet on req_chan as 32-bit network-order words, one beat per
// word, first byte in bits 31:24. byte_count gives the valid leading bytes (1 to 4),
// is_address marks pseudo-header address words (summed, not counted), last marks
// the final word. One result beat on rsp_chan follows each last word: the
// complemented ones'-complement checksum and the counted segment length.
// Set pseudo_mode (index 0) and protocol_number (index 1) through csr_we while idle.
// Throughput: one word per cycle while req_chan.ready is high, set by the per-word
// accumulator update. A last word passes from the input register through the
// finalize register, then the result register, before its result shows on rsp_chan.
// Reset: pseudo_mode returns to none, protocol_number to 6, sums and counts clear,
// and all stages empty.
// Stall: when rsp_chan.ready is low the result holds; words keep flowing until the
// finalize stage holds a last word and another last word sits in the input
// register, then req_chan.ready drops.
`timescale 1ns / 1ps
module internet_checksum_engine (
   input  logic                             clock,
   input  logic                             reset,
   ice_req_if.sink                          req_chan,
   ice_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [ice_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ice_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ice_pkg::*;

   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [PROTO_W-1:0] proto_ff, proto_in;
   ice_cfg_type        cfg;
   ice_total_type      total;
   logic               total_valid;
   logic               total_ready;

   always_comb begin
      mode_in  = mode_ff;
      proto_in = proto_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PSEUDO_MODE: mode_in  = csr_wdata[MODE_W-1:0];
            CSR_PROTOCOL:    proto_in = csr_wdata[PROTO_W-1:0];
            default:         mode_in  = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NONE;
         proto_ff <= PROTOCOL_RESET;
      end else begin
         mode_ff  <= mode_in;
         proto_ff <= proto_in;
      end
   end

   assign cfg.pseudo_mode     = mode_ff;
   assign cfg.protocol_number = proto_ff;

   ice_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .total_valid (total_valid),
      .total_ready (total_ready),
      .total       (total)
   );

   ice_final u_final (
      .clock       (clock),
      .reset       (reset),
      .total_valid (total_valid),
      .total_ready (total_ready),
      .total       (total),
      .cfg         (cfg),
      .rsp_chan    (rsp_chan)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("input stalled while result register is empty");

   a_finalize_backpressure: assert property (@(posedge clock) disable iff (reset)
      (total_valid && !total_ready) |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("finalize stage stalled without a stalled result");

endmodule
